### src/dq_pkg.sv
// dq_pkg: shared types and codes for the double-ended queue
// opcodes, status codes, transfer structs and the controller command group
// no dependencies
package dq_pkg;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned OccWidth = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] push_value;
  } in_t;

  typedef struct packed {
    logic [63:0]         popped_value;
    logic [1:0]          status;
    logic [OccWidth-1:0] occupancy;
  } out_t;

  // command group from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic respond;
  } cmd_t;

endpackage

### src/double_ended_queue.sv
// double_ended_queue: top level of the ring-buffer deque of 64-bit words
// depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram
//
//   channel   handshake        payload                         direction
//   command   start / busy     item_i   (opcode, push_value)   in
//   result    done_o strobe    result_o (popped_value, status, occupancy)  out
//
// - each operation runs through capture, slot ram access and result strobe;
//   the strobe follows the access step due to the registered read port of the slot ram
// - a new command is taken in the cycle after the result strobe
// - reset clears the front pointer and the word count; slots hold no reset
//   value and are only read once written, so there is no clearing pass
// - the result is shown for one cycle with done_o and cannot be stalled
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dq_pkg::in_t   item_i,
  output logic          done_o,
  output dq_pkg::out_t  result_o
);

  dq_pkg::cmd_t cmd;

  // sequencer: one operation in flight at a time
  dq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // pointers, count and slot storage
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .result_o (result_o)
  );

  // strobe in the respond step only
  assign done_o = cmd.respond;

`ifndef SYNTHESIS
  // an accepted command makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // the result strobe falls inside the busy window
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside busy window");

  // a result strobe is never followed at once by another
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // a failed operation never returns a word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != dq_pkg::STATUS_DONE)) |-> (result_o.popped_value == '0))
    else $error("failed operation returned a non-zero word");
`endif

endmodule

### src/dq_ram.sv
// dq_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module dq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/dq_ctrl.sv
// dq_ctrl: sequencer for one queue operation (capture, execute, respond)
// depends on dq_pkg
module dq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output dq_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cmd_o.capture = (state_q == ST_IDLE) && start_i;
  assign cmd_o.execute = (state_q == ST_EXEC);
  assign cmd_o.respond = (state_q == ST_RESP);

endmodule

### src/dq_datapath.sv
// dq_datapath: ring pointers, occupancy count, slot ram and result forming
// depends on dq_pkg and dq_ram
module dq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dq_pkg::cmd_t  cmd_i,
  input  dq_pkg::in_t   item_i,
  output dq_pkg::out_t  result_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned OW = dq_pkg::OccWidth;

  logic [1:0]    op_q;
  logic [63:0]   value_q;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    status_q, status_d;
  logic          pop_ok_q, pop_ok_d;

  logic          is_push, full, empty;
  logic [AW-1:0] front_m1, front_p1, back_idx, last_idx;
  logic [SW-1:0] sum, sum_m1;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   rdata;
  logic [CW+OW-1:0] occ_ext;

  assign is_push = (op_q == dq_pkg::OP_PUSH_FRONT) || (op_q == dq_pkg::OP_PUSH_BACK);
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);

  // ring index arithmetic, every sum stays below twice the depth
  assign front_m1 = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_p1 = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign sum      = SW'(front_q) + SW'(count_q);
  assign sum_m1   = sum - SW'(1);
  assign back_idx = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
  assign last_idx = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = back_idx;
    raddr    = front_q;
    if (cmd_i.execute) begin
      pop_ok_d = 1'b0;
      status_d = dq_pkg::STATUS_DONE;
      if (is_push) begin
        if (full) begin
          status_d = dq_pkg::STATUS_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
          if (op_q == dq_pkg::OP_PUSH_FRONT) begin
            waddr   = front_m1;
            front_d = front_m1;
          end
        end
      end else begin
        if (empty) begin
          status_d = dq_pkg::STATUS_EMPTY;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - CW'(1);
          if (op_q == dq_pkg::OP_POP_FRONT) begin
            front_d = front_p1;
          end else begin
            raddr = last_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= item_i.opcode;
      value_q <= item_i.push_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= dq_pkg::STATUS_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  dq_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign occ_ext               = (CW + OW)'(count_q);
  assign result_o.popped_value = pop_ok_q ? rdata : '0;
  assign result_o.status       = status_q;
  assign result_o.occupancy    = occ_ext[OW-1:0];

endmodule
